>>> sv/assert_macros.svh
// Assertion macros for the matrix multiply engine RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset
`define ASSERT_DIS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_DIS(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/mme_pkg.sv
// Types and constants for the matrix multiply engine.
// No dependencies; used by mme_mac and matrix_multiply_engine.
`default_nettype none

package mme_pkg;

  // Stream and register widths
  localparam int unsigned S_TDATA_W = 40;  // row 3, col 3, value 32, pad 2
  localparam int unsigned M_TDATA_W = 40;  // row 3, col 3, value 32, pad 2
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned PROD_W    = 2 * VAL_W;
  // Up to 15 products of magnitude at most 2^62: 67 bits exact, one spare
  localparam int unsigned ACC_W     = 68;
  // Result queue in front of the output port
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } mme_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DIM = 2'd2
  } mme_status_e;

  // Control travelling with one multiply-accumulate term
  typedef struct packed {
    logic       valid;
    logic       first;      // clears the accumulator
    logic       last_term;  // completes a product element
    logic       last_elem;  // final element of the run
    logic       err;        // dimension mismatch marker
    logic [2:0] row;
    logic [2:0] col;
  } mme_ctrl_t;

  typedef struct packed {
    logic [2:0]       row;
    logic [2:0]       col;
    logic [VAL_W-1:0] value;
    mme_status_e      status;
    logic             last;
  } mme_res_t;

endpackage

`default_nettype wire

>>> sv/matrix_multiply_engine.sv
// Channel  | Dir | Payload (low bit first)                       | Moves on
// s_axis   | in  | tdata: row 3, col 3, value 32; tuser: cmd 2   | tvalid & tready
// m_axis   | out | tdata: row 3, col 3, value 32; tuser: status  | tvalid & tready
// cfg      | in  | cfg_idx_i selects size register, cfg_data_i   | cfg_we_i
//
// Loads are taken back to back while idle. A start issues one
// multiply-accumulate a cycle, limited by the single read port of each store,
// while pending results leave room; terms pass the store read, product,
// accumulator and result registers; a dimension mismatch gives one ST_DIM result.
// Up to four results may be pending; issue pauses while the output stalls.
// After reset the stores hold nothing defined until loaded; no clearing pass.
//
// Top level of the matrix multiply engine. Depends on mme_pkg, mme_mac and
// assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module matrix_multiply_engine import mme_pkg::*; #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Element loads and start commands
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // row_index, col_index, element_value
  input  wire logic [CMD_W-1:0]     s_axis_tuser,   // cmd
  // Product elements
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,   // out_row, out_col, product_value
  output logic [STAT_W-1:0]         m_axis_tuser,   // status
  output logic                      m_axis_tlast,
  // Size registers
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned CMP_W  = (IDX_W > CFG_W) ? IDX_W : CFG_W;
  localparam logic [FIFO_CNT_W-1:0] FULL_CNT = FIFO_CNT_W'(FIFO_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_ERR  = 3'b100
  } mme_state_e;

  // Size clamp: zero counts as one, above MAX_DIM counts as MAX_DIM
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] e;
    if (r == '0) begin
      e = CFG_W'(1);
    end else if (int'(r) > int'(MAX_DIM)) begin
      e = CFG_W'(MAX_DIM);
    end else begin
      e = r;
    end
    return e;
  endfunction

  logic [CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [CFG_W-1:0] ra, ca, rb, cb;

  mme_state_e       state_q, state_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;

  logic             in_xfer, out_xfer;
  mme_cmd_e         cmd;
  logic [2:0]       in_row, in_col;
  logic [VAL_W-1:0] in_val;
  logic             in_range;
  logic [ADDR_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
  logic             we_a, we_b;

  logic [VAL_W-1:0] mem_a_q [DEPTH];
  logic [VAL_W-1:0] mem_b_q [DEPTH];
  logic [VAL_W-1:0] rd_a_q, rd_b_q;

  logic             k_last, c_last, r_last;
  logic             credit, issue, issue_new;
  mme_ctrl_t        ctrl_d, ctrl1_q;
  logic [FIFO_CNT_W-1:0] pend_q, pend_d;

  logic             res_valid;
  mme_res_t         res;
  mme_res_t         fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  mme_res_t         head;

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= CFG_RESET;
      cols_a_q <= CFG_RESET;
      rows_b_q <= CFG_RESET;
      cols_b_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_A: rows_a_q <= cfg_data_i;
        CFG_COLS_A: cols_a_q <= cfg_data_i;
        CFG_ROWS_B: rows_b_q <= cfg_data_i;
        CFG_COLS_B: cols_b_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign ra = eff_dim(rows_a_q);
  assign ca = eff_dim(cols_a_q);
  assign rb = eff_dim(rows_b_q);
  assign cb = eff_dim(cols_b_q);

  // Input unpacking
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign cmd      = mme_cmd_e'(s_axis_tuser);
  assign in_row   = s_axis_tdata[2:0];
  assign in_col   = s_axis_tdata[5:3];
  assign in_val   = s_axis_tdata[37:6];
  assign in_range = (int'(in_row) < int'(MAX_DIM)) && (int'(in_col) < int'(MAX_DIM));
  assign wr_addr  = ADDR_W'(int'(in_row) * int'(MAX_DIM) + int'(in_col));
  assign we_a     = in_xfer && in_range && (cmd == CMD_LOAD_A);
  assign we_b     = in_xfer && in_range && (cmd == CMD_LOAD_B);

  // Element stores: loads write only while idle and read data is used only while
  // the sequencer runs, so the two never meet on an entry
  assign rd_a_addr = ADDR_W'(int'(r_q) * int'(MAX_DIM) + int'(k_q));
  assign rd_b_addr = ADDR_W'(int'(k_q) * int'(MAX_DIM) + int'(c_q));

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a_q[wr_addr] <= in_val;
    end
    rd_a_q <= mem_a_q[rd_a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b_q[wr_addr] <= in_val;
    end
    rd_b_q <= mem_b_q[rd_b_addr];
  end

  // Sequencer over r, c and the inner index k
  assign k_last    = (CMP_W'(k_q) == CMP_W'(ca - CFG_W'(1)));
  assign c_last    = (CMP_W'(c_q) == CMP_W'(cb - CFG_W'(1)));
  assign r_last    = (CMP_W'(r_q) == CMP_W'(ra - CFG_W'(1)));
  assign credit    = (pend_q < FIFO_CNT_W'(FIFO_DEPTH));

  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    c_d       = c_q;
    k_d       = k_q;
    issue     = 1'b0;
    issue_new = 1'b0;
    ctrl_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (cmd == CMD_START)) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = (ca == rb) ? S_RUN : S_ERR;
        end
      end
      S_RUN: begin
        issue     = (k_q != '0) || credit;
        issue_new = issue && (k_q == '0);
        ctrl_d.valid     = issue;
        ctrl_d.first     = (k_q == '0);
        ctrl_d.last_term = k_last;
        ctrl_d.last_elem = k_last && c_last && r_last;
        ctrl_d.row       = 3'(r_q);
        ctrl_d.col       = 3'(c_q);
        if (issue) begin
          if (!k_last) begin
            k_d = k_q + IDX_W'(1);
          end else begin
            k_d = '0;
            if (!c_last) begin
              c_d = c_q + IDX_W'(1);
            end else begin
              c_d = '0;
              if (r_last) begin
                state_d = S_IDLE;
              end else begin
                r_d = r_q + IDX_W'(1);
              end
            end
          end
        end
      end
      S_ERR: begin
        issue     = credit;
        issue_new = credit;
        ctrl_d.valid     = credit;
        ctrl_d.first     = 1'b1;
        ctrl_d.last_term = 1'b1;
        ctrl_d.last_elem = 1'b1;
        ctrl_d.err       = 1'b1;
        if (credit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      ctrl1_q <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      ctrl1_q <= ctrl_d;  // lines up with the registered store data
    end
  end

  // Results in flight or queued; a new element starts only with room left
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign pend_d   = pend_q + FIFO_CNT_W'(issue_new) - FIFO_CNT_W'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  mme_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .a_i         (rd_a_q),
    .b_i         (rd_b_q),
    .ctrl_i      (ctrl1_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output queue
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign cnt_d = cnt_q + FIFO_CNT_W'(res_valid) - FIFO_CNT_W'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {2'b00, head.value, head.col, head.row};
  assign m_axis_tuser  = head.status;
  assign m_axis_tlast  = head.last;

  // Checks
  `ASSERT_DIS(a_pend_bound, clk_i, rst_ni, pend_q <= FULL_CNT, "pending beyond queue depth")
  `ASSERT_DIS(a_no_overflow, clk_i, rst_ni, res_valid |-> cnt_q < FULL_CNT || out_xfer, "overflow")
  `ASSERT_DIS(a_queued_le_pend, clk_i, rst_ni, cnt_q <= pend_q, "queued beyond credited")
  `ASSERT_DIS(a_cnt_bound, clk_i, rst_ni, cnt_q <= FULL_CNT, "queue count beyond depth")

endmodule

`default_nettype wire

>>> sv/mme_mac.sv
// Multiply-accumulate datapath: registered product, wide accumulator,
// floor shift and 32-bit saturation. Depends on mme_pkg.
`default_nettype none

module mme_mac import mme_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [VAL_W-1:0] a_i,
  input  wire logic [VAL_W-1:0] b_i,
  input  wire mme_ctrl_t        ctrl_i,
  output logic                  res_valid_o,
  output mme_res_t              res_o
);

  logic signed [PROD_W-1:0] prod_q;
  mme_ctrl_t                ctrl2_q, ctrl3_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  shifted;
  logic                     fits;
  logic                     res_valid_q;
  mme_res_t                 res_q, res_d;

  // Stage 2: product
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_i) * $signed(b_i);
  end

  // Stage 3: accumulate
  always_comb begin
    acc_d = acc_q;
    if (ctrl2_q.valid) begin
      acc_d = (ctrl2_q.first ? '0 : acc_q)
            + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Stage 4: floor shift and saturate
  always_comb begin
    shifted = acc_q >>> FRAC_BITS;
    fits    = (&shifted[ACC_W-1:VAL_W-1]) | ~(|shifted[ACC_W-1:VAL_W-1]);
    res_d.row  = ctrl3_q.row;
    res_d.col  = ctrl3_q.col;
    res_d.last = ctrl3_q.last_elem;
    if (ctrl3_q.err) begin
      res_d.value  = '0;
      res_d.status = ST_DIM;
    end else if (fits) begin
      res_d.value  = shifted[VAL_W-1:0];
      res_d.status = ST_OK;
    end else begin
      res_d.value  = shifted[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                      : {1'b0, {(VAL_W-1){1'b1}}};
      res_d.status = ST_SAT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl3_q.valid && ctrl3_q.last_term) begin
      res_q <= res_d;
    end
  end

  // Control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl2_q     <= '0;
      ctrl3_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      ctrl2_q     <= ctrl_i;
      ctrl3_q     <= ctrl2_q;
      res_valid_q <= ctrl3_q.valid && ctrl3_q.last_term;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
